// File: rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants of the peak concurrent demand block.
// Holds the store geometry, the field widths and the structs that pass
// between the store, the sweep sequencer and the top level.
// ----------------------------------------------------------------------------
package pcd_pkg;

    localparam int MAX_INTERVALS = 1024;
    localparam int TIME_W        = 31;
    localparam int DEM_W         = 16;
    localparam int PEAK_W        = 26;
    localparam int AW            = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int ACC_W         = CNT_W + DEM_W;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_INTERVALS);
    localparam logic [ACC_W-1:0] PEAK_MAX = ACC_W'((64'd1 << PEAK_W) - 64'd1);

    typedef struct packed {
        logic [TIME_W-1:0] start_t;
        logic [TIME_W-1:0] end_t;
        logic [DEM_W-1:0]  demand;
    } t_entry;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        t_entry        data;
    } t_wr_req;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] n;
        logic             ovf;
    } t_sweep_req;

    typedef struct packed {
        logic              valid;
        logic              busy;
        logic [PEAK_W-1:0] peak;
        logic              ovf;
    } t_sweep_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_ROWDAT,
        S_SCAN,
        S_DONE
    } t_sw_state;

endpackage

// File: rtl/pcd_store.sv
// ----------------------------------------------------------------------------
// pcd_store: interval store.
// One synchronous memory holding start, end and demand of each interval,
// with one write port and one read port whose data is registered.
// ----------------------------------------------------------------------------
module pcd_store (
    input  logic              i_clk,
    input  pcd_pkg::t_wr_req  i_wr,
    input  pcd_pkg::t_rd_req  i_rd,
    output pcd_pkg::t_entry   o_rd_data
);

    pcd_pkg::t_entry r_mem [pcd_pkg::MAX_INTERVALS];
    pcd_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/pcd_sweep.sv
// ----------------------------------------------------------------------------
// pcd_sweep: overlap sweep sequencer.
// For each stored interval it reads the interval, then walks the N stored
// entries and adds up the demand of every interval active at its start
// time. The largest row sum, saturated to the output width, is the result.
// ----------------------------------------------------------------------------
module pcd_sweep (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pcd_pkg::t_sweep_req   i_req,
    input  logic                  i_res_take,
    output pcd_pkg::t_rd_req      o_rd,
    input  pcd_pkg::t_entry       i_rd_data,
    output pcd_pkg::t_sweep_res   o_res
);

    pcd_pkg::t_sw_state r_state, n_state;

    logic [pcd_pkg::CNT_W-1:0]  r_n, n_n;
    logic                       r_ovf, n_ovf;
    logic [pcd_pkg::AW-1:0]     r_i, n_i;
    logic [pcd_pkg::CNT_W-1:0]  r_j, n_j;
    logic [pcd_pkg::AW-1:0]     r_jd, n_jd;
    logic                       r_dv, n_dv;
    logic                       r_hv, n_hv;
    logic [pcd_pkg::DEM_W-1:0]  r_hit_d, n_hit_d;
    logic [pcd_pkg::TIME_W-1:0] r_t, n_t;
    logic [pcd_pkg::ACC_W-1:0]  r_sum, n_sum;
    logic [pcd_pkg::ACC_W-1:0]  r_best, n_best;

    logic scan_issue;
    logic scan_end;
    logic last_row;
    logic hit;

    assign scan_issue = (r_state == pcd_pkg::S_SCAN) && (r_j < r_n);
    assign scan_end   = (r_state == pcd_pkg::S_SCAN) && (r_j == r_n) && !r_dv && !r_hv;
    assign last_row   = (pcd_pkg::CNT_W'({1'b0, r_i}) + pcd_pkg::CNT_W'(1)) == r_n;
    assign hit        = (r_jd == r_i)
                     || ((i_rd_data.start_t <= r_t) && (i_rd_data.end_t > r_t));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcd_pkg::S_IDLE: begin
                if (i_req.start) begin
                    n_state = pcd_pkg::S_ROW;
                end
            end
            pcd_pkg::S_ROW: begin
                n_state = pcd_pkg::S_ROWDAT;
            end
            pcd_pkg::S_ROWDAT: begin
                n_state = pcd_pkg::S_SCAN;
            end
            pcd_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = last_row ? pcd_pkg::S_DONE : pcd_pkg::S_ROW;
                end
            end
            pcd_pkg::S_DONE: begin
                if (i_res_take) begin
                    n_state = pcd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pcd_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_rd.en   = (r_state == pcd_pkg::S_ROW) || scan_issue;
        o_rd.addr = (r_state == pcd_pkg::S_ROW) ? r_i : r_j[pcd_pkg::AW-1:0];
        o_res.valid = (r_state == pcd_pkg::S_DONE);
        o_res.busy  = (r_state != pcd_pkg::S_IDLE);
        o_res.peak  = (r_best > pcd_pkg::PEAK_MAX) ? pcd_pkg::PEAK_MAX[pcd_pkg::PEAK_W-1:0]
                                                   : r_best[pcd_pkg::PEAK_W-1:0];
        o_res.ovf   = r_ovf;
    end

    // Datapath: read stage, hit stage, then accumulate.
    always_comb begin
        n_n     = r_n;
        n_ovf   = r_ovf;
        n_i     = r_i;
        n_j     = r_j;
        n_t     = r_t;
        n_sum   = r_sum;
        n_best  = r_best;
        n_jd    = r_j[pcd_pkg::AW-1:0];
        n_dv    = scan_issue;
        n_hv    = r_dv;
        n_hit_d = (r_dv && hit) ? i_rd_data.demand : '0;

        if (r_state == pcd_pkg::S_IDLE && i_req.start) begin
            n_n    = i_req.n;
            n_ovf  = i_req.ovf;
            n_i    = '0;
            n_best = '0;
        end
        if (r_state == pcd_pkg::S_ROWDAT) begin
            n_t   = i_rd_data.start_t;
            n_j   = '0;
            n_sum = '0;
        end
        if (scan_issue) begin
            n_j = r_j + pcd_pkg::CNT_W'(1);
        end
        if (r_hv) begin
            n_sum = r_sum + pcd_pkg::ACC_W'(r_hit_d);
        end
        if (scan_end) begin
            if (r_sum > r_best) begin
                n_best = r_sum;
            end
            if (!last_row) begin
                n_i = r_i + pcd_pkg::AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcd_pkg::S_IDLE;
            r_dv    <= 1'b0;
            r_hv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            r_hv    <= n_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_ovf   <= n_ovf;
        r_i     <= n_i;
        r_j     <= n_j;
        r_jd    <= n_jd;
        r_hit_d <= n_hit_d;
        r_t     <= n_t;
        r_sum   <= n_sum;
        r_best  <= n_best;
    end

endmodule

// File: rtl/peak_concurrent_demand_top.sv
// ----------------------------------------------------------------------------
// peak_concurrent_demand_top: peak weighted interval overlap.
// Loads intervals into an on-chip store and, on the request flagged last,
// reports the largest total demand active at any interval's start.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ----------------------------
//  in        input      i_in_valid / o_in_ready    start, end, count, last flag
//  out       output     o_out_valid / i_out_ready  peak_machines, overflowed
//
// A request that is not flagged last is written to the store on acceptance;
// such requests may follow each other in every cycle.
// A request flagged last starts the sweep. Each of the N stored intervals
// is handled in turn: the row is fetched, N reads go through the single
// read port and the compare and add pipeline is drained.
// Reset clears the fill count, the overflow flag, the sequencer and the
// output valid flag; the store contents are not cleared.
// The input is not ready during the sweep, and the sweep holds its result
// until the output register is free, so a stalled output stalls the input.
// ----------------------------------------------------------------------------
module peak_concurrent_demand_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [pcd_pkg::TIME_W-1:0]  i_start_time,
    input  logic [pcd_pkg::TIME_W-1:0]  i_end_time,
    input  logic [pcd_pkg::DEM_W-1:0]   i_machine_count,
    input  logic                        i_last_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [pcd_pkg::PEAK_W-1:0]  o_peak_machines,
    output logic                        o_overflowed
);

    // Fill count and overflow flag of the set being loaded.
    logic [pcd_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_ovf, n_ovf;

    // Output register.
    logic                       r_out_valid, n_out_valid;
    logic [pcd_pkg::PEAK_W-1:0] r_peak;
    logic                       r_out_ovf;

    logic                       in_accept;
    logic                       has_room;
    logic                       res_take;
    pcd_pkg::t_wr_req           wr;
    pcd_pkg::t_rd_req           rd;
    pcd_pkg::t_entry            rd_data;
    pcd_pkg::t_sweep_req        sw_req;
    pcd_pkg::t_sweep_res        sw_res;

    assign o_in_ready = !sw_res.busy;
    assign in_accept  = i_in_valid && o_in_ready;
    assign has_room   = (r_cnt < pcd_pkg::CNT_MAX);

    // A request lands in the store while there is room; otherwise it is
    // dropped and the overflow flag is raised for the set.
    always_comb begin
        wr.en           = in_accept && has_room;
        wr.addr         = r_cnt[pcd_pkg::AW-1:0];
        wr.data.start_t = i_start_time;
        wr.data.end_t   = i_end_time;
        wr.data.demand  = i_machine_count;
    end

    // The count and flag seen by the sweep include the last request itself.
    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (in_accept) begin
            if (has_room) begin
                n_cnt = r_cnt + pcd_pkg::CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
        sw_req.start = in_accept && i_last_item;
        sw_req.n     = n_cnt;
        sw_req.ovf   = n_ovf;
        if (sw_req.start) begin
            n_cnt = '0;
            n_ovf = 1'b0;
        end
    end

    // The sweep hands over its result once the output register is free
    // or is being emptied in this cycle.
    assign res_take = sw_res.valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (res_take) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_peak    <= sw_res.peak;
            r_out_ovf <= sw_res.ovf;
        end
    end

    pcd_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd      (rd),
        .o_rd_data (rd_data)
    );

    pcd_sweep u_sweep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (sw_req),
        .i_res_take (res_take),
        .o_rd       (rd),
        .i_rd_data  (rd_data),
        .o_res      (sw_res)
    );

    assign o_out_valid     = r_out_valid;
    assign o_peak_machines = r_peak;
    assign o_overflowed    = r_out_ovf;

endmodule

// File: test/tb_peak_concurrent_demand_top.sv
// ----------------------------------------------------------------------------
// tb_peak_concurrent_demand_top: self-checking bench for the peak demand block.
// Sends sets of intervals over the request channel, predicts the peak
// concurrent demand and the overflow flag of every set, and checks each
// result that leaves the output channel against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_peak_concurrent_demand_top;

    // One pending request: the interval and its end-of-set flag.
    typedef struct packed {
        pcd_pkg::t_entry iv;
        logic            last;
    } t_interval_req;

    // What one completed set is expected to report.
    typedef struct {
        logic [pcd_pkg::PEAK_W-1:0] peak;
        logic                       ovf;
    } t_peak_result;

    localparam logic [pcd_pkg::TIME_W-1:0] T_MAX       = '1;
    localparam logic [pcd_pkg::DEM_W-1:0]  DEM_MAX     = '1;
    localparam longint                     PEAK_LIMIT  = (64'd1 << pcd_pkg::PEAK_W) - 1;
    localparam int                         RANDOM_REQS = 460;
    // The limit covers the full-store sweep, the small random sets, the
    // idling on both sides and the long output hold with room to spare.
    localparam int                         CYCLE_LIMIT = 6_000_000;
    localparam int                         HOLD_AT     = 10;
    localparam int                         HOLD_CYCLES = 4000;
    localparam int                         DRAIN_TAIL  = 64;

    logic                         i_clk           = 1'b0;
    logic                         i_rst_n         = 1'b0;
    logic                         i_in_valid      = 1'b0;
    logic                         o_in_ready;
    logic [pcd_pkg::TIME_W-1:0]   i_start_time    = '0;
    logic [pcd_pkg::TIME_W-1:0]   i_end_time      = '0;
    logic [pcd_pkg::DEM_W-1:0]    i_machine_count = '0;
    logic                         i_last_item     = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_ready     = 1'b0;
    logic [pcd_pkg::PEAK_W-1:0]   o_peak_machines;
    logic                         o_overflowed;

    peak_concurrent_demand_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_start_time    (i_start_time),
        .i_end_time      (i_end_time),
        .i_machine_count (i_machine_count),
        .i_last_item     (i_last_item),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_peak_machines (o_peak_machines),
        .o_overflowed    (o_overflowed)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus waiting to be sent, and the predicted results in send order.
    t_interval_req pending_intervals[$];
    t_peak_result  expected_peaks[$];

    // The bench's own copy of the block state: the intervals of the set
    // being loaded and whether any were dropped for lack of room.
    pcd_pkg::t_entry held_intervals[$];
    logic            set_overflow = 1'b0;

    int            error_count  = 0;
    int            cycle_count  = 0;
    int            results_seen = 0;
    t_peak_result  oldest_peak;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR cycle %0d: %s", cycle_count, what);
    endtask

    task automatic add_request(input logic [pcd_pkg::TIME_W-1:0] s,
                               input logic [pcd_pkg::TIME_W-1:0] e,
                               input logic [pcd_pkg::DEM_W-1:0] d, input logic last);
        t_interval_req req;
        req.iv.start_t = s;
        req.iv.end_t   = e;
        req.iv.demand  = d;
        req.last       = last;
        pending_intervals.insert(pending_intervals.size(), req);
    endtask

    // Peak of the held set: for every interval, its own demand plus that of
    // every other interval already started at its start and not yet released
    // there. An interval releases exactly at its end time.
    function automatic logic [pcd_pkg::PEAK_W-1:0] peak_demand_of_set();
        longint best;
        longint sum;
        best = 0;
        foreach (held_intervals[i]) begin
            sum = held_intervals[i].demand;
            foreach (held_intervals[j]) begin
                if (j != i && held_intervals[j].start_t <= held_intervals[i].start_t
                    && held_intervals[j].end_t > held_intervals[i].start_t) begin
                    sum += held_intervals[j].demand;
                end
            end
            if (sum > best) begin
                best = sum;
            end
        end
        if (best > PEAK_LIMIT) begin
            best = PEAK_LIMIT;
        end
        return best[pcd_pkg::PEAK_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. It sends in bursts of random length separated by random
    // gaps; some bursts are long so that back-to-back requests also occur.
    // Every accepted request is applied to the predictor at the edge that
    // accepts it, using the payload that the block saw at that edge.
    // ------------------------------------------------------------------------
    int            burst_left = 0;
    int            gap_left   = 0;
    t_interval_req next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                // A full store drops the interval, the last one included.
                if (held_intervals.size() < pcd_pkg::MAX_INTERVALS) begin
                    held_intervals.insert(held_intervals.size(),
                        pcd_pkg::t_entry'{i_start_time, i_end_time, i_machine_count});
                end else begin
                    set_overflow = 1'b1;
                end
                if (i_last_item) begin
                    expected_peaks.insert(expected_peaks.size(),
                        t_peak_result'{peak_demand_of_set(), set_overflow});
                    held_intervals.delete();
                    set_overflow = 1'b0;
                end
            end
            // A request that is offered stays unchanged until accepted.
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_intervals.size() != 0) begin
                    next_req = pending_intervals.pop_front();
                    i_start_time    <= next_req.iv.start_t;
                    i_end_time      <= next_req.iv.end_t;
                    i_machine_count <= next_req.iv.demand;
                    i_last_item     <= next_req.last;
                    i_in_valid      <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                                  : $urandom_range(1, 12);
                        gap_left   <= $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output receiver. It switches between stretches of always ready, random
    // ready and mostly stalled. Once a few results have passed it holds off
    // for a long stretch: the block then finishes its sweep, keeps the result
    // and must stop taking requests although the driver keeps offering them.
    // ------------------------------------------------------------------------
    int mode_left = 0;
    int ready_mode = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 2);
                mode_left  <= $urandom_range(16, 200);
            end else begin
                mode_left  <= mode_left - 1;
            end
            case (ready_mode)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= 1'($urandom_range(0, 1));
                end
                default: begin
                    i_out_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: every accepted result is matched against the oldest
    // prediction, field by field. A result with nothing predicted is an error.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (expected_peaks.size() == 0) begin
                report_mismatch($sformatf("unexpected result peak=%0d overflowed=%0b",
                                          o_peak_machines, o_overflowed));
            end else begin
                oldest_peak = expected_peaks.pop_front();
                if (o_peak_machines !== oldest_peak.peak) begin
                    report_mismatch($sformatf("peak_machines %0d, expected %0d",
                                              o_peak_machines, oldest_peak.peak));
                end
                if (o_overflowed !== oldest_peak.ovf) begin
                    report_mismatch($sformatf("overflowed %0b, expected %0b",
                                              o_overflowed, oldest_peak.ovf));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run. All requests are queued up front; the driver
    // takes them as the handshake allows.
    // ------------------------------------------------------------------------
    int                         random_sent;
    int                         set_len;
    int                         time_style;
    logic [pcd_pkg::TIME_W-1:0] s_t;
    logic [pcd_pkg::TIME_W-1:0] e_t;
    logic [pcd_pkg::DEM_W-1:0]  dem;

    initial begin
        // Single intervals at both extremes of every field.
        add_request('0, '0, '0, 1'b1);
        add_request(T_MAX, T_MAX, DEM_MAX, 1'b1);

        // Release at a start equal to an end, a zero-length interval, an
        // interval that ends before it starts and one spanning all time.
        add_request(31'd5, 31'd10, 16'd100, 1'b0);
        add_request(31'd10, 31'd20, 16'd200, 1'b0);
        add_request(31'd5, 31'd5, 16'd7, 1'b0);
        add_request(31'd7, 31'd3, 16'd1, 1'b0);
        add_request('0, T_MAX, DEM_MAX, 1'b1);

        // Several intervals sharing a start count each other there.
        add_request(31'd3, 31'd9, 16'd1, 1'b0);
        add_request(31'd3, 31'd9, 16'd2, 1'b0);
        add_request(31'd3, 31'd4, 16'd4, 1'b0);
        add_request(T_MAX, '0, DEM_MAX, 1'b0);
        add_request('0, 31'd1, DEM_MAX, 1'b1);

        // Alternating bit patterns in every field.
        add_request(31'h2AAA_AAAA, 31'h5555_5555, 16'hAAAA, 1'b0);
        add_request(31'h5555_5555, 31'h2AAA_AAAA, 16'h5555, 1'b1);

        // Store full: the store is filled, then one plain request and the
        // last request are both dropped. The result still comes, flagged.
        for (int k = 0; k < pcd_pkg::MAX_INTERVALS + 2; k++) begin
            add_request(pcd_pkg::TIME_W'($urandom_range(0, 63)),
                        pcd_pkg::TIME_W'($urandom_range(0, 63)),
                        pcd_pkg::DEM_W'($urandom()), k == pcd_pkg::MAX_INTERVALS + 1);
        end

        // Random sets, mostly short so that the quadratic sweep stays cheap.
        // Each set picks a time style: dense small times full of ties, the
        // whole range, the top of the range, or well-formed short intervals.
        random_sent = 0;
        while (random_sent < RANDOM_REQS) begin
            set_len    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                     : $urandom_range(1, 12);
            time_style = $urandom_range(0, 3);
            for (int k = 0; k < set_len; k++) begin
                case (time_style)
                    0: begin
                        s_t = pcd_pkg::TIME_W'($urandom_range(0, 15));
                        e_t = pcd_pkg::TIME_W'($urandom_range(0, 15));
                    end
                    1: begin
                        s_t = pcd_pkg::TIME_W'($urandom());
                        e_t = pcd_pkg::TIME_W'($urandom());
                    end
                    2: begin
                        s_t = T_MAX - pcd_pkg::TIME_W'($urandom_range(0, 15));
                        e_t = T_MAX - pcd_pkg::TIME_W'($urandom_range(0, 15));
                    end
                    default: begin
                        s_t = pcd_pkg::TIME_W'($urandom_range(0, 1000));
                        e_t = s_t + pcd_pkg::TIME_W'($urandom_range(0, 50));
                    end
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    dem = $urandom_range(0, 1) ? DEM_MAX : '0;
                end else begin
                    dem = pcd_pkg::DEM_W'($urandom());
                end
                add_request(s_t, e_t, dem, k == set_len - 1);
            end
            random_sent += set_len;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every request accepted, every result back, then a short tail in
        // which nothing further may appear. The checks run at the falling
        // edge, when the driver and the monitor have settled.
        while (pending_intervals.size() != 0 || i_in_valid) begin
            @(negedge i_clk);
        end
        while (expected_peaks.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_TAIL) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/pcd_pkg.sv
rtl/pcd_store.sv
rtl/pcd_sweep.sv
rtl/peak_concurrent_demand_top.sv
test/tb_peak_concurrent_demand_top.sv
